>>> sv/acit_pkg.sv
// Shared types, widths and constants of the adaptive checkpoint interval block.
// No dependencies; every other file imports it.
package acit_pkg;

  localparam int unsigned MAX_INTERVAL   = 1024;
  localparam int unsigned START_INTERVAL = 2;

  localparam int unsigned SZ_IN_W  = 32;
  localparam int unsigned IV_W     = 11;
  localparam int unsigned CK_W     = 11;
  localparam int unsigned PB_W     = 8;
  localparam int unsigned BS_W     = 33;
  localparam int unsigned DS_W     = 44;
  localparam int unsigned WS_W     = 54;
  localparam int unsigned RAT_W    = 16;
  localparam int unsigned PEN_W    = 12;
  localparam int unsigned B_W      = BS_W + RAT_W;
  localparam int unsigned WT_W     = 19;
  localparam int unsigned DEN_W    = WS_W + PEN_W;
  localparam int unsigned ACC_W    = B_W + WT_W;
  localparam int unsigned MB_W     = 19;
  localparam int unsigned Q_W      = 13;
  localparam int unsigned DIV_SH   = Q_W - 1;
  localparam int unsigned DV_W     = DEN_W + DIV_SH;
  localparam int unsigned CNT_W    = $clog2(Q_W + 1);
  localparam int unsigned NXT_W    = IV_W + 1;

  localparam int unsigned TDATA_IN_W  = 80;
  localparam int unsigned TUSER_IN_W  = 3;
  localparam int unsigned TDATA_OUT_W = 16;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic [RAT_W-1:0] RATIO_RST   = 16'd512;
  localparam logic [PB_W-1:0]  PROBE_RST   = 8'd8;
  localparam logic [PEN_W-1:0] PENALTY_RST = 12'd256;

  typedef enum logic [1:0] {
    MODE_RECORD  = 2'd0,
    MODE_DECIDE  = 2'd1,
    MODE_RESTART = 2'd2
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SIZE_RATIO  = 2'd0,
    CFG_PROBE_LIMIT = 2'd1,
    CFG_LOG_PENALTY = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_REC,
    S_B,
    S_W,
    S_DEN,
    S_NUM,
    S_DIV,
    S_FIN,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [RAT_W-1:0] size_ratio;
    logic [PB_W-1:0]  probe_cap;
    logic [PEN_W-1:0] log_weight;
  } cfg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

  typedef struct packed {
    logic start;
    logic res_ready;
  } core_ctl_t;

  typedef struct packed {
    logic idle;
    logic res_valid;
  } core_sts_t;

endpackage

>>> sv/acit_mul.sv
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
// Depends on acit_pkg.
module acit_mul
  import acit_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [ACC_W-1:0] a_i,
  input  logic [MB_W-1:0]  b_i,
  output unit_sts_t        sts_o,
  output logic [ACC_W-1:0] p_o
);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [ACC_W-1:0] ma_q, ma_d;
  logic [ACC_W-1:0] acc_q, acc_d;
  logic [MB_W-1:0]  mb_q, mb_d;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
    end else if (busy_q && (mb_q == '0)) begin
      busy_d = 1'b0;
      done_d = 1'b1;
    end
  end

  always_comb begin
    ma_d  = ma_q;
    mb_d  = mb_q;
    acc_d = acc_q;
    if (start_i) begin
      ma_d  = a_i;
      mb_d  = b_i;
      acc_d = '0;
    end else if (busy_q && (mb_q != '0)) begin
      if (mb_q[0]) begin
        acc_d = acc_q + ma_q;
      end
      ma_d = ma_q << 1;
      mb_d = mb_q >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ma_q  <= ma_d;
    mb_q  <= mb_d;
    acc_q <= acc_d;
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign p_o        = acc_q;

endmodule

>>> sv/acit_div.sv
// Restoring divider, one quotient bit per cycle, thirteen quotient bits.
// Depends on acit_pkg; the top quotient bit flags a quotient of 4096 or more.
module acit_div
  import acit_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [ACC_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output unit_sts_t        sts_o,
  output logic [Q_W-1:0]   q_o
);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [ACC_W-1:0] rem_q, rem_d;
  logic [DV_W-1:0]  dv_q, dv_d;
  logic [Q_W-1:0]   q_q, q_d;
  logic             ge;

  assign ge = {{(DV_W-ACC_W){1'b0}}, rem_q} >= dv_q;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(Q_W);
    end else if (busy_q) begin
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_comb begin
    rem_d = rem_q;
    dv_d  = dv_q;
    q_d   = q_q;
    if (start_i) begin
      rem_d = num_i;
      dv_d  = {den_i, {DIV_SH{1'b0}}};
      q_d   = '0;
    end else if (busy_q) begin
      if (ge) begin
        rem_d = rem_q - dv_q[ACC_W-1:0];
      end
      q_d  = {q_q[Q_W-2:0], ge};
      dv_d = dv_q >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dv_q  <= dv_d;
    q_q   <= q_d;
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign q_o        = q_q;

endmodule

>>> sv/acit_core.sv
// Sequencer and checkpoint state: record, decide and restart steps.
// Depends on acit_pkg, acit_mul and acit_div.
module acit_core
  import acit_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  core_ctl_t          ctl_i,
  input  mode_e              mode_i,
  input  logic               is_base_i,
  input  logic [SZ_IN_W-1:0] delta_size_i,
  input  logic [SZ_IN_W-1:0] index_size_i,
  input  logic [IV_W-1:0]    restart_interval_i,
  input  cfg_t               cfg_i,
  output core_sts_t          sts_o,
  output logic [IV_W-1:0]    current_interval_o,
  output logic               logging_enable_o,
  output logic               next_is_base_o
);

  state_e state_q, state_d;

  logic [IV_W-1:0]  interval_q, interval_d;
  logic [CK_W-1:0]  ckpt_q, ckpt_d;
  logic [PB_W-1:0]  probe_q, probe_d;
  logic [BS_W-1:0]  base_q, base_d;
  logic [DS_W-1:0]  dsum_q, dsum_d;
  logic [WS_W-1:0]  wsum_q, wsum_d;

  logic [BS_W-1:0]  size_q, size_d;
  logic [B_W-1:0]   bprod_q, bprod_d;
  logic [WT_W-1:0]  wtri_q, wtri_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [NXT_W-1:0] nxt_q, nxt_d;

  logic             mul_start;
  logic [ACC_W-1:0] mul_a;
  logic [MB_W-1:0]  mul_b;
  logic [ACC_W-1:0] mul_p;
  unit_sts_t        mul_sts;
  logic             div_start;
  logic [Q_W-1:0]   div_q;
  unit_sts_t        div_sts;

  logic [BS_W-1:0]  size_in;
  logic [IV_W-1:0]  rst_cl;
  logic             decide_skip;
  logic             b_le;
  logic             w_zero;
  logic [NXT_W-1:0] dbl;
  logic [IV_W-1:0]  half;
  logic [DS_W:0]    dsum_add;
  logic [WS_W:0]    wsum_add;
  logic [NXT_W-1:0] nxt_div;
  logic [NXT_W-1:0] nxt_sat;
  logic [PB_W:0]    probe_inc;

  acit_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .sts_o   (mul_sts),
    .p_o     (mul_p)
  );

  acit_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (mul_p),
    .den_i   (den_q),
    .sts_o   (div_sts),
    .q_o     (div_q)
  );

  assign size_in     = {1'b0, delta_size_i} + {1'b0, index_size_i};
  assign decide_skip = (interval_q == IV_W'(1)) || (ckpt_q <= CK_W'(1));
  assign b_le        = {{(DS_W+8-B_W){1'b0}}, mul_p[B_W-1:0]} <= {dsum_q, 8'b0};
  assign w_zero      = (wsum_q == '0) || (cfg_i.log_weight == '0);
  assign dbl         = {interval_q, 1'b0};
  assign dsum_add    = {1'b0, dsum_q} + (DS_W+1)'(size_q);
  assign wsum_add    = {1'b0, wsum_q} + (WS_W+1)'(mul_p[DS_W-1:0]);
  assign nxt_sat     = (nxt_q > NXT_W'(MAX_INTERVAL)) ? NXT_W'(MAX_INTERVAL) : nxt_q;
  assign probe_inc   = {1'b0, probe_q} + (PB_W+1)'(1);

  always_comb begin
    if (restart_interval_i == '0) begin
      rst_cl = IV_W'(1);
    end else if (restart_interval_i > IV_W'(MAX_INTERVAL)) begin
      rst_cl = IV_W'(MAX_INTERVAL);
    end else begin
      rst_cl = restart_interval_i;
    end
  end

  always_comb begin
    half = interval_q >> 1;
    if (half == '0) begin
      half = IV_W'(1);
    end
  end

  always_comb begin
    if (div_q == '0) begin
      nxt_div = NXT_W'(1);
    end else if (div_q < Q_W'(dbl)) begin
      nxt_div = NXT_W'(div_q) + NXT_W'(1);
    end else begin
      nxt_div = dbl;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (ctl_i.start) begin
          case (mode_i)
            MODE_RECORD: state_d = is_base_i ? S_DONE : S_REC;
            MODE_DECIDE: state_d = decide_skip ? S_DONE : S_B;
            default:     state_d = S_DONE;
          endcase
        end
      end
      S_REC: begin
        if (mul_sts.done) state_d = S_DONE;
      end
      S_B: begin
        if (mul_sts.done) state_d = b_le ? S_FIN : S_W;
      end
      S_W: begin
        if (mul_sts.done) state_d = w_zero ? S_FIN : S_DEN;
      end
      S_DEN: begin
        if (mul_sts.done) state_d = S_NUM;
      end
      S_NUM: begin
        if (mul_sts.done) state_d = S_DIV;
      end
      S_DIV: begin
        if (div_sts.done) state_d = S_FIN;
      end
      S_FIN: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        if (ctl_i.res_ready) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // unit starts and operands
  always_comb begin
    mul_start = 1'b0;
    div_start = 1'b0;
    mul_a     = ACC_W'(size_in);
    mul_b     = MB_W'(ckpt_q);
    case (state_q)
      S_IDLE: begin
        if (mode_i == MODE_DECIDE) begin
          mul_a = ACC_W'(base_q);
          mul_b = MB_W'(cfg_i.size_ratio);
        end
        if (ctl_i.start) begin
          case (mode_i)
            MODE_RECORD: mul_start = !is_base_i;
            MODE_DECIDE: mul_start = !decide_skip;
            default:     mul_start = 1'b0;
          endcase
        end
      end
      S_B: begin
        mul_a     = ACC_W'(interval_q - IV_W'(1));
        mul_b     = MB_W'(interval_q);
        mul_start = mul_sts.done && !b_le;
      end
      S_W: begin
        mul_a     = ACC_W'(wsum_q);
        mul_b     = MB_W'(cfg_i.log_weight);
        mul_start = mul_sts.done && !w_zero;
      end
      S_DEN: begin
        mul_a     = ACC_W'(bprod_q);
        mul_b     = MB_W'(wtri_q);
        mul_start = mul_sts.done;
      end
      S_NUM: begin
        div_start = mul_sts.done;
      end
      default: begin
        mul_start = 1'b0;
      end
    endcase
  end

  // state and working registers
  always_comb begin
    interval_d = interval_q;
    ckpt_d     = ckpt_q;
    probe_d    = probe_q;
    base_d     = base_q;
    dsum_d     = dsum_q;
    wsum_d     = wsum_q;
    size_d     = size_q;
    bprod_d    = bprod_q;
    wtri_d     = wtri_q;
    den_d      = den_q;
    nxt_d      = nxt_q;
    case (state_q)
      S_IDLE: begin
        if (ctl_i.start) begin
          size_d = size_in;
          case (mode_i)
            MODE_RECORD: begin
              if (is_base_i) begin
                if ((interval_q == IV_W'(1)) && (probe_q != '1)) begin
                  probe_d = probe_q + PB_W'(1);
                end
                base_d = size_in;
                if (ckpt_q != '1) ckpt_d = ckpt_q + CK_W'(1);
              end
            end
            MODE_DECIDE: begin
              if (interval_q == IV_W'(1)) begin
                if (probe_q == cfg_i.probe_cap) begin
                  interval_d = IV_W'(2);
                  probe_d    = '0;
                end
                ckpt_d = CK_W'(1);
              end
            end
            MODE_RESTART: begin
              interval_d = rst_cl;
              ckpt_d     = '0;
            end
            default: begin
              size_d = size_in;
            end
          endcase
        end
      end
      S_REC: begin
        if (mul_sts.done) begin
          dsum_d = dsum_add[DS_W] ? '1 : dsum_add[DS_W-1:0];
          wsum_d = wsum_add[WS_W] ? '1 : wsum_add[WS_W-1:0];
          if (ckpt_q != '1) ckpt_d = ckpt_q + CK_W'(1);
        end
      end
      S_B: begin
        if (mul_sts.done) begin
          bprod_d = mul_p[B_W-1:0];
          nxt_d   = NXT_W'(half);
        end
      end
      S_W: begin
        if (mul_sts.done) begin
          wtri_d = mul_p[WT_W:1];
          nxt_d  = dbl;
        end
      end
      S_DEN: begin
        if (mul_sts.done) den_d = mul_p[DEN_W-1:0];
      end
      S_DIV: begin
        if (div_sts.done) nxt_d = nxt_div;
      end
      S_FIN: begin
        interval_d = nxt_sat[IV_W-1:0];
        dsum_d     = '0;
        wsum_d     = '0;
        ckpt_d     = CK_W'(1);
        if (nxt_sat == NXT_W'(1)) probe_d = '0;
      end
      default: begin
        nxt_d = nxt_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      interval_q <= IV_W'(START_INTERVAL);
      ckpt_q     <= '0;
      probe_q    <= '0;
      base_q     <= '0;
      dsum_q     <= '0;
      wsum_q     <= '0;
    end else begin
      state_q    <= state_d;
      interval_q <= interval_d;
      ckpt_q     <= ckpt_d;
      probe_q    <= probe_d;
      base_q     <= base_d;
      dsum_q     <= dsum_d;
      wsum_q     <= wsum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    size_q  <= size_d;
    bprod_q <= bprod_d;
    wtri_q  <= wtri_d;
    den_q   <= den_d;
    nxt_q   <= nxt_d;
  end

  always_comb begin
    if (interval_q == IV_W'(1)) begin
      logging_enable_o = (probe_inc == {1'b0, cfg_i.probe_cap});
    end else begin
      logging_enable_o = (ckpt_q == interval_q) || (ckpt_q < (interval_q - IV_W'(1)));
    end
  end

  assign next_is_base_o     = (ckpt_q == interval_q) || (ckpt_q == '0);
  assign current_interval_o = interval_q;
  assign sts_o.idle         = (state_q == S_IDLE);
  assign sts_o.res_valid    = (state_q == S_DONE);

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.start |-> state_q == S_IDLE)
    else $error("word started while sequencer busy");

  a_fin_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FIN |=> ckpt_q == CK_W'(1) && dsum_q == '0 && wsum_q == '0)
    else $error("decide did not clear sums and count");

  a_fin_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FIN |=> interval_q != '0 && interval_q <= IV_W'(MAX_INTERVAL))
    else $error("decided interval out of range");

  a_mul_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_start |-> !mul_sts.busy)
    else $error("multiplier restarted while busy");

  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && ctl_i.start && mode_i == MODE_RESTART) |=>
      ckpt_q == '0 && interval_q != '0)
    else $error("restart did not load interval");

endmodule

>>> sv/adaptive_checkpoint_interval_top.sv
// Adaptive checkpoint interval chooser: one result word for every input word.
// A base record, a restart, an unused mode or a decide that changes nothing goes
// from acceptance straight to the done state and on to the output register; a
// delta record waits for one product of the bit-serial shift-and-add multiplier,
// which stops once the checkpoint count is shifted out. A full decide runs four
// serial products (base times ratio, the triangular weight, weighted sum times
// penalty, and the numerator), one multiplier bit per cycle, then a 13-step
// restoring divider. A new word is accepted once the sequencer is idle, while
// the previous result may still wait in the output register.
//
// Top level: configuration registers, stream handshake and output register.
// Depends on acit_pkg and acit_core.
module adaptive_checkpoint_interval_top
  import acit_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // delta_size[31:0], index_size[63:32], restart_interval[74:64], zero fill
  input  logic [TDATA_IN_W-1:0]  s_axis_tdata,
  // mode[1:0], is_base[2]
  input  logic [TUSER_IN_W-1:0]  s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // current_interval[10:0], logging_enable[11], next_is_base[12], zero fill
  output logic [TDATA_OUT_W-1:0] m_axis_tdata,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i
);

  cfg_t                   cfg_q, cfg_d;
  logic                   out_valid_q, out_valid_d;
  logic [TDATA_OUT_W-1:0] out_data_q, out_data_d;

  core_ctl_t              core_ctl;
  core_sts_t              core_sts;
  logic [IV_W-1:0]        res_interval;
  logic                   res_log;
  logic                   res_base;
  logic                   res_load;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = core_sts.idle;

  assign core_ctl.start     = s_axis_tvalid && s_axis_tready;
  assign core_ctl.res_ready = !out_valid_q || m_axis_tready;
  assign res_load           = core_sts.res_valid && core_ctl.res_ready;

  acit_core u_core (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .ctl_i              (core_ctl),
    .mode_i             (mode_e'(s_axis_tuser[1:0])),
    .is_base_i          (s_axis_tuser[2]),
    .delta_size_i       (s_axis_tdata[SZ_IN_W-1:0]),
    .index_size_i       (s_axis_tdata[2*SZ_IN_W-1:SZ_IN_W]),
    .restart_interval_i (s_axis_tdata[2*SZ_IN_W+IV_W-1:2*SZ_IN_W]),
    .cfg_i              (cfg_q),
    .sts_o              (core_sts),
    .current_interval_o (res_interval),
    .logging_enable_o   (res_log),
    .next_is_base_o     (res_base)
  );

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_SIZE_RATIO:  cfg_d.size_ratio = cfg_data_i[RAT_W-1:0];
        CFG_PROBE_LIMIT: cfg_d.probe_cap  = cfg_data_i[PB_W-1:0];
        CFG_LOG_PENALTY: cfg_d.log_weight = cfg_data_i[PEN_W-1:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (res_load) begin
      out_valid_d = 1'b1;
      out_data_d  = {{(TDATA_OUT_W-IV_W-2){1'b0}}, res_base, res_log, res_interval};
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.size_ratio <= RATIO_RST;
      cfg_q.probe_cap  <= PROBE_RST;
      cfg_q.log_weight <= PENALTY_RST;
      out_valid_q      <= 1'b0;
    end else begin
      cfg_q       <= cfg_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule
